>>> design/tvmw_pkg.sv
// Package for the three-voice mixer / waveshaper.
// Holds widths, register indexes, shaper mode codes and shared structs.
// No dependencies.
package tvmw_pkg;

    localparam int BLOCK_SIZE = 32;
    localparam int POS_W      = 6;
    localparam int HOLD_W     = 5;
    localparam int SAMPLE_W   = 8;
    localparam int GAIN_W     = 8;
    localparam int FUZZ_W     = 7;
    localparam int MODE_W     = 6;
    localparam int PROD_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [SAMPLE_W-1:0] MIDPOINT = 8'd128;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FUZZ        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTE        = 3'd5;

    localparam logic [MODE_W-1:0] MODE_MASK    = 6'd1;
    localparam logic [MODE_W-1:0] MODE_HOLD    = 6'd2;
    localparam logic [MODE_W-1:0] MODE_QUARTER = 6'd3;
    localparam logic [MODE_W-1:0] MODE_FLIP    = 6'd4;
    localparam logic [MODE_W-1:0] MODE_STRETCH = 6'd5;
    localparam logic [MODE_W-1:0] MODE_FOLD    = 6'd6;

    typedef struct packed {
        logic [GAIN_W-1:0] base_gain;
        logic [GAIN_W-1:0] first_division_gain;
        logic [GAIN_W-1:0] second_division_gain;
        logic [FUZZ_W-1:0] fuzz_amount;
        logic [MODE_W-1:0] shaper_mode;
        logic              mute;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                bypass;
    } mixed_t;

endpackage

>>> design/tvmw_if.sv
// Channel interfaces for the mixer: voice samples in, mixed sample out, config writes.
// Depends on tvmw_pkg.
interface tvmw_voice_if
    import tvmw_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] root_sample;
    logic [SAMPLE_W-1:0] first_division_sample;
    logic [SAMPLE_W-1:0] second_division_sample;

    modport source (output valid, root_sample, first_division_sample,
                    second_division_sample, input ready);
    modport sink   (input valid, root_sample, first_division_sample,
                    second_division_sample, output ready);
endinterface

interface tvmw_mix_if
    import tvmw_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] mixed_sample;

    modport source (output valid, mixed_sample, input ready);
    modport sink   (input valid, mixed_sample, output ready);
endinterface

interface tvmw_cfg_if
    import tvmw_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/three_voice_mixer_waveshaper.sv
// Top level of the three-voice mixer / waveshaper.
// Depends on tvmw_pkg, tvmw_if, tvmw_cfg, tvmw_mix, tvmw_shape.
//
// Usage:
//   voices : request of three unsigned 8-bit oscillator samples (valid/ready).
//   mix    : one unsigned 8-bit mixed_sample per request (valid/ready).
//   cfg    : register writes, index 0..5 = root gain, first division gain,
//            second division gain, fuzz amount, shaper mode, mute. Always ready;
//            indexes above 5 are ignored. Write only while the block is idle.
// Pipeline: a request passes the product, mix and result registers in turn;
//   the three stages hand over independently, so bubbles close up.
// Throughput: one request per cycle unless mix stalls; a new request is taken
//   while a result waits.
// Reset: config registers clear to 0, block position and hold count to 0, held
//   value to 128; the pipeline empties.
// Stall: when mix.ready is low the result register holds; up to three
//   requests sit in the stages before voices.ready drops.
module three_voice_mixer_waveshaper
    import tvmw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tvmw_voice_if.sink   voices,
    tvmw_mix_if.source   mix,
    tvmw_cfg_if.sink     cfg
);

    cfg_t   cfg_q;
    logic   m_valid;
    logic   m_ready;
    mixed_t m_data;

    assign cfg.ready = 1'b1;

    tvmw_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_q)
    );

    tvmw_mix u_mix (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg                    (cfg_q),
        .in_valid               (voices.valid),
        .in_ready               (voices.ready),
        .root_sample            (voices.root_sample),
        .first_division_sample  (voices.first_division_sample),
        .second_division_sample (voices.second_division_sample),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_data                 (m_data)
    );

    tvmw_shape u_shape (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_q),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .out_valid  (mix.valid),
        .out_ready  (mix.ready),
        .out_sample (mix.mixed_sample)
    );

endmodule

>>> design/tvmw_cfg.sv
// Configuration register file: gains, fuzz amount, shaper mode, mute.
// Depends on tvmw_pkg.
module tvmw_cfg
    import tvmw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_ROOT_GAIN:   cfg_next.base_gain            = wr_data;
                CFG_FIRST_GAIN:  cfg_next.first_division_gain  = wr_data;
                CFG_SECOND_GAIN: cfg_next.second_division_gain = wr_data;
                CFG_FUZZ:        cfg_next.fuzz_amount          = wr_data[FUZZ_W-1:0];
                CFG_MODE:        cfg_next.shaper_mode          = wr_data[MODE_W-1:0];
                CFG_MUTE:        cfg_next.mute                 = wr_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/tvmw_mix.sv
// Mixer front end: registered gain products, then sum, slice and centering offset.
// Depends on tvmw_pkg.
module tvmw_mix
    import tvmw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] root_sample,
    input  logic [SAMPLE_W-1:0] first_division_sample,
    input  logic [SAMPLE_W-1:0] second_division_sample,
    output logic                m_valid,
    input  logic                m_ready,
    output mixed_t              m_data
);

    logic              p_valid_reg;
    logic [PROD_W-1:0] prod_a_reg;
    logic [PROD_W-1:0] prod_b_reg;
    logic [PROD_W-1:0] prod_c_reg;
    logic              m_valid_reg;
    mixed_t            m_data_reg;
    mixed_t            m_data_next;

    logic              adv_p;
    logic              adv_m;
    logic [PROD_W-1:0] sum;
    logic [GAIN_W-1:0] gain_total;
    logic [SAMPLE_W-1:0] centre;
    logic              gains_zero;

    assign adv_m    = !m_valid_reg || m_ready;
    assign adv_p    = !p_valid_reg || adv_m;
    assign in_ready = adv_p;

    always_comb
    begin
        sum        = prod_a_reg + prod_b_reg + prod_c_reg;
        gain_total = cfg.base_gain + cfg.first_division_gain + cfg.second_division_gain;
        centre     = gain_total[7] ? '0 : {1'b0, ~gain_total[6:0]};
        gains_zero = (cfg.base_gain == '0) && (cfg.first_division_gain == '0)
                     && (cfg.second_division_gain == '0);
        m_data_next.bypass = cfg.mute || gains_zero;
        m_data_next.sample = m_data_next.bypass ? MIDPOINT : sum[14:7] + centre;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_p)
            begin
                p_valid_reg <= in_valid;
            end
            if (adv_m)
            begin
                m_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_p && in_valid)
        begin
            prod_a_reg <= {8'b0, root_sample} * {8'b0, cfg.base_gain};
            prod_b_reg <= {8'b0, first_division_sample} * {8'b0, cfg.first_division_gain};
            prod_c_reg <= {8'b0, second_division_sample} * {8'b0, cfg.second_division_gain};
        end
        if (adv_m && p_valid_reg)
        begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> design/tvmw_shape.sv
// Waveshaper back end: seven shapers, sample-hold state, block position, result register.
// Depends on tvmw_pkg.
module tvmw_shape
    import tvmw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                m_valid,
    output logic                m_ready,
    input  mixed_t              m_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SAMPLE_W-1:0] out_sample
);

    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_sample_reg;
    logic [SAMPLE_W-1:0] out_sample_next;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic [HOLD_W-1:0]   hold_rem_reg;
    logic [HOLD_W-1:0]   hold_rem_next;
    logic [SAMPLE_W-1:0] held_reg;
    logic [SAMPLE_W-1:0] held_next;

    logic                load;
    logic [SAMPLE_W-1:0] s;
    logic [FUZZ_W-1:0]   f;
    logic [HOLD_W-1:0]   hold_len;
    logic                holding;
    logic [SAMPLE_W-1:0] two_f;
    logic [SAMPLE_W-1:0] shaped;
    logic [8:0]          sat_sum;
    logic [SAMPLE_W-1:0] fp1;
    logic [6:0]          stretch_x;
    logic [SAMPLE_W-1:0] stretch_k;
    logic [14:0]         stretch_p;
    logic [SAMPLE_W-1:0] stretch_t;
    logic [9:0]          fold_t;
    logic [SAMPLE_W-1:0] drive_a;
    logic [SAMPLE_W-1:0] drive_b;
    logic [15:0]         drive_p;
    logic [POS_W:0]      pos_inc;

    assign m_ready = !out_valid_reg || out_ready;
    assign load    = m_valid && m_ready;

    always_comb
    begin
        s        = m_data.sample;
        f        = cfg.fuzz_amount;
        two_f    = {f, 1'b0};
        hold_len = f[HOLD_W-1:0];

        sat_sum   = {1'b0, s} + {1'b0, two_f};
        fp1       = {1'b0, f} + 8'd1;
        stretch_x = s[7] ? s[6:0] : ~s[6:0];
        stretch_k = {1'b0, f} + 8'd4;
        stretch_p = {8'b0, stretch_x} * {7'b0, stretch_k};
        stretch_t = stretch_p[9:2];
        fold_t    = {2'b00, s} + {1'b0, f, 2'b00};
        drive_a   = s[7] ? 8'd255 - s : s;
        drive_b   = s[7] ? two_f : {~f, 1'b0};
        drive_p   = {8'b0, drive_a} * {8'b0, drive_b};

        unique case (cfg.shaper_mode)
            MODE_MASK:
            begin
                shaped = s[7] ? (s & ~{1'b0, f}) + {1'b0, f} : s & ~{1'b0, f};
            end
            MODE_QUARTER:
            begin
                if (s[6])
                    shaped = (s > two_f) ? s - two_f : '0;
                else
                    shaped = sat_sum[8] ? 8'd255 : sat_sum[7:0];
            end
            MODE_FLIP:
            begin
                shaped = s ^ {fp1[6:0], 1'b0};
            end
            MODE_STRETCH:
            begin
                if (s[7])
                    shaped = stretch_t[7] ? {1'b1, ~stretch_t[6:0]} : {1'b1, stretch_t[6:0]};
                else
                    shaped = stretch_t[7] ? {1'b0, stretch_t[6:0]} : {1'b0, ~stretch_t[6:0]};
            end
            MODE_FOLD:
            begin
                shaped = fold_t[8] ? ~fold_t[7:0] : fold_t[7:0];
            end
            MODE_HOLD:
            begin
                shaped = s;
            end
            default:
            begin
                shaped = s[7] ? s + drive_p[15:8] : drive_p[15:8];
            end
        endcase

        holding = !m_data.bypass && (f != '0) && (cfg.shaper_mode == MODE_HOLD)
                  && (hold_len > 5'd1);

        held_next     = held_reg;
        hold_rem_next = '0;
        if (m_data.bypass || f == '0)
            out_sample_next = s;
        else
            out_sample_next = shaped;
        if (holding)
        begin
            if (pos_reg == '0 || hold_rem_reg == '0)
            begin
                held_next       = s;
                hold_rem_next   = hold_len - 5'd1;
                out_sample_next = s;
            end
            else
            begin
                hold_rem_next   = hold_rem_reg - 5'd1;
                out_sample_next = held_reg;
            end
        end

        pos_inc  = {1'b0, pos_reg} + 7'd1;
        pos_next = (pos_inc >= (POS_W+1)'(BLOCK_SIZE)) ? '0 : pos_inc[POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            hold_rem_reg  <= '0;
            held_reg      <= MIDPOINT;
        end
        else
        begin
            if (m_ready)
            begin
                out_valid_reg <= m_valid;
            end
            if (load)
            begin
                pos_reg      <= pos_next;
                hold_rem_reg <= hold_rem_next;
                held_reg     <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_sample_reg <= out_sample_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;

endmodule

>>> design/tvmw_checker.sv
// Port-level checker for the mixer: stall behavior and request accounting.
// Depends on tvmw_pkg; bound to three_voice_mixer_waveshaper.
module tvmw_checker
    import tvmw_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                voices_valid,
    input logic                voices_ready,
    input logic                mix_valid,
    input logic                mix_ready,
    input logic [SAMPLE_W-1:0] mix_sample
);

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       acc;
    logic       del;

    assign acc = voices_valid && voices_ready;
    assign del = mix_valid && mix_ready;

    always_comb
    begin
        pending_next = pending_reg + {2'b00, acc} - {2'b00, del};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mix_valid && !mix_ready |=> mix_valid && $stable(mix_sample))
        else $error("result changed while stalled");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("more than three requests in flight");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        mix_valid |-> pending_reg != 3'd0)
        else $error("result without a pending request");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 3'd0 |-> voices_ready)
        else $error("empty pipeline refuses a request");

endmodule

bind three_voice_mixer_waveshaper tvmw_checker u_tvmw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .voices_valid (voices.valid),
    .voices_ready (voices.ready),
    .mix_valid    (mix.valid),
    .mix_ready    (mix.ready),
    .mix_sample   (mix.mixed_sample)
);
